>>> sv/owrse_pkg.sv
// Shared types and constants for the 1-Wire ROM search decision engine.
`timescale 1ns / 1ps

package owrse_pkg;

    localparam int ROM_BITS = 64;
    localparam int POS_W    = $clog2(ROM_BITS + 1);
    localparam int IDX_W    = $clog2(ROM_BITS);
    localparam int CODE_W   = 64;
    localparam int COUNT_W  = 8;

    localparam logic [7:0]         CMD_SEARCH = 8'hF0;
    localparam logic [7:0]         CMD_ALARM  = 8'hEC;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 88;
    localparam int M_USER_W = 3;
    localparam int PADDR_W  = 3;

    localparam logic [PADDR_W-1:0] REG_ALARM_ONLY = 3'd0;

    typedef enum logic [0:0] {
        MODE_START = 1'b0,
        MODE_PAIR  = 1'b1
    } owrse_mode_t;

    typedef enum logic [2:0] {
        KIND_COMMAND = 3'd0,
        KIND_WRITE   = 3'd1,
        KIND_FOUND   = 3'd2,
        KIND_ABORT   = 3'd3,
        KIND_DONE    = 3'd4,
        KIND_IGNORED = 3'd5
    } owrse_kind_t;

    typedef struct packed {
        logic [ROM_BITS-1:0] rom_bits;
        logic [POS_W-1:0]    last_fork;
        logic [POS_W-1:0]    pass_fork;
        logic [POS_W-1:0]    bit_position;
        logic                in_pass;
        logic                search_finished;
        logic [COUNT_W-1:0]  device_total;
    } owrse_state_t;

    typedef struct packed {
        owrse_kind_t        kind;
        logic [7:0]         command_byte;
        logic               direction_bit;
        logic [CODE_W-1:0]  rom_code;
        logic               more_remain;
        logic [COUNT_W-1:0] found_count;
    } owrse_result_t;

endpackage

>>> sv/owrse_step.sv
// One decision step of the search tree walk: next state and result word.
`timescale 1ns / 1ps

module owrse_step (
    input  owrse_pkg::owrse_state_t  state,
    input  logic                     alarm_only,
    input  owrse_pkg::owrse_mode_t   mode,
    input  logic                     presence,
    input  logic                     true_bit,
    input  logic                     complement_bit,
    output owrse_pkg::owrse_state_t  state_next,
    output owrse_pkg::owrse_result_t result
);

    logic [owrse_pkg::POS_W-1:0] pos;
    logic [owrse_pkg::IDX_W-1:0] sh;
    logic                        dir;

    assign pos = state.bit_position;
    assign sh  = owrse_pkg::IDX_W'(pos - owrse_pkg::POS_W'(1));

    always_comb
    begin
        state_next = state;
        result     = '0;
        result.kind        = owrse_pkg::KIND_IGNORED;
        result.found_count = state.device_total;
        dir = 1'b0;

        if (mode == owrse_pkg::MODE_START)
        begin
            if (state.search_finished || !presence)
            begin
                result.kind = state.search_finished ? owrse_pkg::KIND_DONE
                                                    : owrse_pkg::KIND_ABORT;
                state_next.in_pass         = 1'b0;
                state_next.last_fork       = '0;
                state_next.pass_fork       = '0;
                state_next.bit_position    = owrse_pkg::POS_W'(1);
                state_next.search_finished = 1'b0;
                state_next.device_total    = '0;
            end
            else
            begin
                result.kind         = owrse_pkg::KIND_COMMAND;
                result.command_byte = alarm_only ? owrse_pkg::CMD_ALARM
                                                 : owrse_pkg::CMD_SEARCH;
                state_next.in_pass      = 1'b1;
                state_next.bit_position = owrse_pkg::POS_W'(1);
                state_next.pass_fork    = '0;
            end
        end
        else if (state.in_pass)
        begin
            if (true_bit && complement_bit)
            begin
                result.kind = owrse_pkg::KIND_ABORT;
                state_next.in_pass         = 1'b0;
                state_next.last_fork       = '0;
                state_next.pass_fork       = '0;
                state_next.bit_position    = owrse_pkg::POS_W'(1);
                state_next.search_finished = 1'b0;
                state_next.device_total    = '0;
            end
            else
            begin
                // fork: replay the previous ROM below the last fork, turn at it, take 0 past it
                if (!true_bit && !complement_bit)
                begin
                    if (pos < state.last_fork)
                    begin
                        dir = state.rom_bits[sh];
                        if (!dir)
                        begin
                            state_next.pass_fork = pos;
                        end
                    end
                    else if (pos == state.last_fork)
                    begin
                        dir = 1'b1;
                    end
                    else
                    begin
                        dir = 1'b0;
                        state_next.pass_fork = pos;
                    end
                end
                else
                begin
                    dir = true_bit;
                end

                state_next.rom_bits[sh] = dir;
                result.direction_bit    = dir;

                if (pos >= owrse_pkg::POS_W'(owrse_pkg::ROM_BITS))
                begin
                    result.kind        = owrse_pkg::KIND_FOUND;
                    result.rom_code    = owrse_pkg::CODE_W'(state_next.rom_bits);
                    result.more_remain = (state_next.pass_fork != '0);
                    state_next.last_fork = state_next.pass_fork;
                    if (state.device_total != owrse_pkg::COUNT_MAX)
                    begin
                        state_next.device_total = state.device_total + 1'b1;
                    end
                    result.found_count      = state_next.device_total;
                    state_next.in_pass      = 1'b0;
                    state_next.bit_position = owrse_pkg::POS_W'(1);
                    if (state_next.pass_fork == '0)
                    begin
                        state_next.search_finished = 1'b1;
                    end
                end
                else
                begin
                    result.kind = owrse_pkg::KIND_WRITE;
                    state_next.bit_position = pos + owrse_pkg::POS_W'(1);
                end
            end
        end
    end

endmodule

>>> sv/onewire_rom_search_engine_unit.sv
// Top level of the 1-Wire ROM search decision engine: ports, pipeline, state.
//
// channel  dir  tdata                                   tuser
// s_       in   presence, true_bit, complement_bit      mode
// m_       out  command_byte, direction_bit, rom_code,  kind
//               more_remain, found_count
// apb      in   reg 0 at 0x0: alarm_only
//
// One word per cycle sustained while m_tready is high; each taken word goes
// through the input register, then the result register. The search state lives
// next to the result register, so each word sees what the word before it left.
// Reset clears the search state, alarm_only and both valid flags.
// A stall on m_tready holds the result register and backs up through the
// input register to s_tready.
`timescale 1ns / 1ps

module onewire_rom_search_engine_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [0] presence, [1] true_bit, [2] complement_bit, [7:3] zero
    input  logic [owrse_pkg::S_DATA_W-1:0]     s_tdata,
    // [0] mode
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] command_byte, [8] direction_bit, [72:9] rom_code,
    // [73] more_remain, [81:74] found_count, [87:82] zero
    output logic [owrse_pkg::M_DATA_W-1:0]     m_tdata,
    // [2:0] kind
    output logic [owrse_pkg::M_USER_W-1:0]     m_tuser,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [owrse_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic                     alarm_only_reg;
    logic                     in_valid_reg;
    owrse_pkg::owrse_mode_t   in_mode_reg;
    logic [2:0]               in_bits_reg;
    logic                     out_valid_reg;
    owrse_pkg::owrse_result_t out_result_reg;
    owrse_pkg::owrse_state_t  state_reg;
    owrse_pkg::owrse_state_t  state_next;
    owrse_pkg::owrse_result_t result_next;
    logic                     advance;
    logic                     reg_sel;

    assign reg_sel  = (paddr[owrse_pkg::PADDR_W-1] == owrse_pkg::REG_ALARM_ONLY[2]);
    assign pready   = 1'b1;
    assign prdata   = reg_sel ? {31'd0, alarm_only_reg} : 32'd0;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    owrse_step u_step (
        .state          (state_reg),
        .alarm_only     (alarm_only_reg),
        .mode           (in_mode_reg),
        .presence       (in_bits_reg[0]),
        .true_bit       (in_bits_reg[1]),
        .complement_bit (in_bits_reg[2]),
        .state_next     (state_next),
        .result         (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_only_reg            <= 1'b0;
            in_valid_reg              <= 1'b0;
            out_valid_reg             <= 1'b0;
            state_reg.rom_bits        <= '0;
            state_reg.last_fork       <= '0;
            state_reg.pass_fork       <= '0;
            state_reg.bit_position    <= owrse_pkg::POS_W'(1);
            state_reg.in_pass         <= 1'b0;
            state_reg.search_finished <= 1'b0;
            state_reg.device_total    <= '0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && reg_sel)
            begin
                alarm_only_reg <= pwdata[0];
            end

            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end

            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_mode_reg <= owrse_pkg::owrse_mode_t'(s_tuser);
            in_bits_reg <= s_tdata[2:0];
        end
        if (advance)
        begin
            out_result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.kind;
    assign m_tdata  = {6'd0,
                       out_result_reg.found_count,
                       out_result_reg.more_remain,
                       out_result_reg.rom_code,
                       out_result_reg.direction_bit,
                       out_result_reg.command_byte};

endmodule

>>> sv/owrse_checker.sv
// Port-level checks for the ROM search engine, bound to the top level.
`timescale 1ns / 1ps

module owrse_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [owrse_pkg::M_DATA_W-1:0]     m_tdata,
    input logic [owrse_pkg::M_USER_W-1:0]     m_tuser
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed under stall");

    // a command word carries one of the two search commands
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == owrse_pkg::KIND_COMMAND) |->
            (m_tdata[7:0] == owrse_pkg::CMD_SEARCH) ||
            (m_tdata[7:0] == owrse_pkg::CMD_ALARM))
        else $error("bad command byte");

    // ROM code and more flag only on a found word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != owrse_pkg::KIND_FOUND) |->
            (m_tdata[73:9] == '0))
        else $error("rom code outside found word");

    // direction bit only on write and found words, command only on command words
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != owrse_pkg::KIND_WRITE) &&
            (m_tuser != owrse_pkg::KIND_FOUND) |->
            !m_tdata[8] &&
            ((m_tuser == owrse_pkg::KIND_COMMAND) || (m_tdata[7:0] == 8'd0)))
        else $error("stray direction or command field");

endmodule

bind onewire_rom_search_engine_unit owrse_checker u_owrse_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
